// ===== rtl/hwe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and tables of the Hardy-Weinberg EM frequency block.
// Used by every module of the block; depends on nothing.
package hwe_pkg;

    // Sizes
    localparam int MAX_SAMPLES    = 1024;
    localparam int MAX_ALLELES    = 4;
    localparam int MAX_ROUNDS     = 50;
    localparam int PL_TABLE_DEPTH = 256;
    localparam int MAX_GENO       = MAX_ALLELES * (MAX_ALLELES + 1) / 2;
    localparam int STORE_DEPTH    = MAX_SAMPLES * MAX_GENO;

    // Widths
    localparam int ADDR_W   = $clog2(STORE_DEPTH);
    localparam int SMP_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W    = SMP_W + 1;
    localparam int ALLELE_W = $clog2(MAX_ALLELES);
    localparam int GENO_W   = 4;
    localparam int TBL_W    = $clog2(PL_TABLE_DEPTH);
    localparam int PL_W     = 16;
    localparam int PROB_W   = 24;
    localparam int FREQ_W   = 25;
    localparam int W_W      = 48;
    localparam int SUM_W    = 52;
    localparam int NORM_BIT = 39;
    localparam int SH_W     = 4;
    localparam int ACC_W    = 40;
    localparam int NUM_W    = 64;
    localparam int DEN_W    = 40;
    localparam int QUO_W    = 25;
    localparam int SQ_W     = 50;
    localparam int MSE_W    = 52;
    localparam int ROUND_W  = 6;
    localparam int TOL_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [FREQ_W-1:0] ONE_Q24 = FREQ_W'(1 << 24);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLOIDY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLELES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL     = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ALLELE = 2'd0;
    localparam logic [1:0] KIND_GENO   = 2'd1;
    localparam logic [1:0] KIND_NODATA = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_PRIOR,
        OP_RDW,
        OP_NORM,
        OP_DIVW,
        OP_ACC,
        OP_DIVU,
        OP_UPD,
        OP_SQ,
        OP_MSE,
        OP_REND,
        OP_EMIT_AF,
        OP_EMIT_G,
        OP_NODATA
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic               load;
        logic [GENO_W-1:0]  idx;
        logic [SMP_W-1:0]   smp;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0]         nalleles;
        logic [GENO_W-1:0]  ngenos;
        logic [CNT_W-1:0]   nsamples;
        logic               nodata;
        logic               pipe_busy;
        logic               sum_zero;
        logic               norm_done;
        logic               div_done;
        logic               more_rounds;
    } dp_stat_t;

    typedef struct packed {
        logic [ALLELE_W-1:0] hi;
        logic [ALLELE_W-1:0] lo;
    } geno_pair_t;

    // Triangular genotype index to allele pair
    function automatic geno_pair_t geno_pair(input logic [GENO_W-1:0] k);
        geno_pair_t p;
        case (k)
            4'd0:    p = '{hi: 2'd0, lo: 2'd0};
            4'd1:    p = '{hi: 2'd1, lo: 2'd0};
            4'd2:    p = '{hi: 2'd1, lo: 2'd1};
            4'd3:    p = '{hi: 2'd2, lo: 2'd0};
            4'd4:    p = '{hi: 2'd2, lo: 2'd1};
            4'd5:    p = '{hi: 2'd2, lo: 2'd2};
            4'd6:    p = '{hi: 2'd3, lo: 2'd0};
            4'd7:    p = '{hi: 2'd3, lo: 2'd1};
            4'd8:    p = '{hi: 2'd3, lo: 2'd2};
            4'd9:    p = '{hi: 2'd3, lo: 2'd3};
            default: p = '{hi: 2'd0, lo: 2'd0};
        endcase
        return p;
    endfunction

    // Genotypes per sample for a given allele count
    function automatic logic [GENO_W-1:0] genos(input logic [2:0] a);
        logic [GENO_W-1:0] g;
        case (a)
            3'd2:    g = 4'd3;
            3'd3:    g = 4'd6;
            3'd4:    g = 4'd10;
            default: g = 4'd3;
        endcase
        return g;
    endfunction

    // Rounded 1/a in Q0.24
    function automatic logic [FREQ_W-1:0] uniform_af(input logic [2:0] a);
        logic [FREQ_W-1:0] f;
        case (a)
            3'd2:    f = 25'd8388608;
            3'd3:    f = 25'd5592405;
            3'd4:    f = 25'd4194304;
            default: f = 25'd8388608;
        endcase
        return f;
    endfunction

    // PHRED to probability table, Q0.24
    typedef logic [PROB_W-1:0] phred_tab_t [PL_TABLE_DEPTH];

    localparam logic [63:0] TENTH_Q24 [10] = '{
        64'd16777216, 64'd13326616, 64'd10585708, 64'd8408526, 64'd6679130,
        64'd5305422,  64'd4214246,  64'd3347495,  64'd2659010, 64'd2112126
    };

    function automatic phred_tab_t build_phred();
        phred_tab_t  t;
        logic [63:0] v;
        int          q;
        int          r;
        int          k;
        for (k = 0; k < PL_TABLE_DEPTH; k++) begin
            q = k / 10;
            r = k % 10;
            v = TENTH_Q24[r];
            case (q)
                0:       v = v;
                1:       v = (v + 64'd5) / 64'd10;
                2:       v = (v + 64'd50) / 64'd100;
                3:       v = (v + 64'd500) / 64'd1000;
                4:       v = (v + 64'd5000) / 64'd10000;
                5:       v = (v + 64'd50000) / 64'd100000;
                6:       v = (v + 64'd500000) / 64'd1000000;
                7:       v = (v + 64'd5000000) / 64'd10000000;
                default: v = 64'd0;
            endcase
            if (v > 64'hFFFFFF) v = 64'hFFFFFF;
            t[k] = v[PROB_W-1:0];
        end
        return t;
    endfunction

    localparam phred_tab_t PHRED_TABLE = build_phred();

endpackage

// ===== rtl/hwe_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, QUO_W steps.
// Depends on hwe_pkg; quotient must fit QUO_W bits.
module hwe_div import hwe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);
    localparam int STEP_W = $clog2(QUO_W);

    logic                 run_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     rem_next;
    logic [DEN_W-1:0]     den_reg;
    logic [QUO_W-1:0]     low_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 bit_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;

    // One trial subtraction
    always_comb
    begin
        shifted = {rem_reg, low_reg[QUO_W-1]};
        diff    = shifted - {1'b0, den_reg};
        if (!diff[DEN_W])
        begin
            rem_next = diff[DEN_W-1:0];
            bit_next = 1'b1;
        end
        else
        begin
            rem_next = shifted[DEN_W-1:0];
            bit_next = 1'b0;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DEN_W'(dividend[NUM_W-1:QUO_W]);
            low_reg <= dividend[QUO_W-1:0];
            den_reg <= divisor;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], bit_next};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/hwe_dp.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, likelihood store, weight pipeline, EM arithmetic,
// result registers. Depends on hwe_pkg and hwe_div.
module hwe_dp import hwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [TOL_W-1:0]      wr_data,
    input  logic [PL_W-1:0]       pl_value,
    input  logic                  pl_missing,
    output logic                  strobe,
    output logic [1:0]            kind,
    output logic [3:0]            index,
    output logic [FREQ_W-1:0]     freq,
    output logic [CNT_W-1:0]      samples_used,
    output logic [ROUND_W-1:0]    rounds,
    output logic                  last
);
    // Config
    logic [3:0]         ploidy_reg;
    logic [2:0]         acnt_reg;
    logic [TOL_W-1:0]   tol_reg;

    // Loader
    logic [CNT_W-1:0]   cnt_reg;
    logic [GENO_W-1:0]  pos_reg;
    logic               kept_reg;
    logic [2:0]         a_ld;
    logic [GENO_W-1:0]  g_ld;
    logic [GENO_W-1:0]  pos_eff;
    logic               kept_now;
    logic               st_we;
    logic [PL_W-1:0]    st_wdata;
    logic [ADDR_W-1:0]  ld_addr;
    logic [ADDR_W-1:0]  em_addr;
    logic               ld_clear;

    // Store
    logic [PL_W-1:0]    mem [STORE_DEPTH];
    logic [PL_W-1:0]    rd_data_reg;

    // EM state
    logic [FREQ_W-1:0]  af_reg    [MAX_ALLELES];
    logic [FREQ_W-1:0]  prior_reg [MAX_GENO];
    logic [ACC_W-1:0]   acc_reg   [MAX_ALLELES];
    logic [W_W-1:0]     w_reg     [MAX_GENO];
    logic [SUM_W-1:0]   sum_reg;
    logic [SH_W-1:0]    sh_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [FREQ_W-1:0]  d_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [MSE_W-1:0]   mse_reg;

    // Weight pipeline
    logic               v1_reg, v2_reg, v3_reg;
    logic [GENO_W-1:0]  t1_reg, t2_reg;
    logic [PROB_W-1:0]  tbl_reg;
    logic [W_W-1:0]     prod_reg;
    logic [TBL_W-1:0]   tbl_idx;
    logic [W_W:0]       wprod;

    // Shared arithmetic
    geno_pair_t            gp;
    logic [ALLELE_W-1:0]   ia;
    logic [2*FREQ_W-1:0]   af_prod;
    logic [2*FREQ_W:0]     af_dbl;
    logic [2*FREQ_W:0]     af_rnd;
    logic [FREQ_W-1:0]     pf_val;
    logic [W_W-1:0]        w_sh;
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic                  div_done;
    logic [QUO_W-1:0]      div_q;
    logic [FREQ_W-1:0]     nf;
    logic [FREQ_W-1:0]     af_sel;

    // Output registers
    logic                  strobe_reg;
    logic [1:0]            kind_reg;
    logic [3:0]            index_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [CNT_W-1:0]      samples_reg;
    logic [ROUND_W-1:0]    rounds_reg;
    logic                  last_reg;

    // Loader decode
    always_comb
    begin
        if (acnt_reg < 3'd2)
            a_ld = 3'd2;
        else if (acnt_reg > 3'(MAX_ALLELES))
            a_ld = 3'(MAX_ALLELES);
        else
            a_ld = acnt_reg;
        g_ld     = genos(a_ld);
        pos_eff  = (pos_reg >= g_ld) ? '0 : pos_reg;
        kept_now = (pos_eff == '0) ?
                   (!pl_missing && (cnt_reg < CNT_W'(MAX_SAMPLES))) : kept_reg;
        st_we    = cmd.load && kept_now;
        st_wdata = pl_missing ? {PL_W{1'b1}} : pl_value;
        ld_addr  = ADDR_W'(ADDR_W'(cnt_reg[SMP_W-1:0]) * ADDR_W'(g_ld)) + ADDR_W'(pos_eff);
        em_addr  = ADDR_W'(ADDR_W'(cmd.smp) * ADDR_W'(g_ld)) + ADDR_W'(cmd.idx);
        ld_clear = (cmd.op == OP_NODATA) ||
                   ((cmd.op == OP_EMIT_G) && (cmd.idx == g_ld - 1'b1));
    end

    // Likelihood store, registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
            mem[ld_addr] <= st_wdata;
        rd_data_reg <= mem[em_addr];
    end

    // Pair frequency: one multiplier for priors and genotype results
    always_comb
    begin
        gp      = geno_pair(cmd.idx);
        ia      = cmd.idx[ALLELE_W-1:0];
        af_prod = af_reg[gp.hi] * af_reg[gp.lo];
        af_dbl  = (gp.hi != gp.lo) ? {af_prod, 1'b0} : {1'b0, af_prod};
        af_rnd  = af_dbl + (2*FREQ_W+1)'(1 << 23);
        if (af_rnd[2*FREQ_W:24] > (2*FREQ_W-23)'(ONE_Q24))
            pf_val = ONE_Q24;
        else
            pf_val = af_rnd[24 +: FREQ_W];
    end

    // Table lookup and weight product
    always_comb
    begin
        tbl_idx = (rd_data_reg >= PL_W'(PL_TABLE_DEPTH)) ?
                  TBL_W'(PL_TABLE_DEPTH - 1) : rd_data_reg[TBL_W-1:0];
        wprod   = prior_reg[t2_reg] * tbl_reg;
    end

    // Divider operand select
    always_comb
    begin
        w_sh      = w_reg[cmd.idx] >> sh_reg;
        div_start = (cmd.op == OP_DIVW) || (cmd.op == OP_DIVU);
        if (cmd.op == OP_DIVU)
        begin
            div_num = NUM_W'(acc_reg[ia]) + NUM_W'(cnt_reg);
            div_den = DEN_W'({cnt_reg, 1'b0});
        end
        else
        begin
            div_num = {w_sh[DEN_W-1:0], 24'd0} + NUM_W'(sum_reg >> 1);
            div_den = sum_reg[DEN_W-1:0];
        end
        nf     = (div_q > ONE_Q24) ? ONE_Q24 : div_q;
        af_sel = af_reg[ia];
    end

    hwe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Control registers: config, loader, pipeline valids, rounds, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ploidy_reg <= 4'd2;
            acnt_reg   <= 3'd2;
            tol_reg    <= TOL_W'(4295);
            cnt_reg    <= '0;
            pos_reg    <= '0;
            kept_reg   <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            round_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_PLOIDY:  ploidy_reg <= wr_data[3:0];
                    REG_ALLELES: acnt_reg   <= wr_data[2:0];
                    REG_TOL:     tol_reg    <= wr_data;
                    default:     ;
                endcase
            end

            // Sample loader
            if (cmd.load)
            begin
                if (pos_eff == g_ld - 1'b1)
                begin
                    if (kept_now)
                        cnt_reg <= cnt_reg + 1'b1;
                    kept_reg <= 1'b0;
                    pos_reg  <= '0;
                end
                else
                begin
                    kept_reg <= kept_now;
                    pos_reg  <= pos_eff + 1'b1;
                end
            end
            else if (ld_clear)
            begin
                cnt_reg  <= '0;
                pos_reg  <= '0;
                kept_reg <= 1'b0;
            end

            v1_reg <= (cmd.op == OP_RDW);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;

            if (cmd.op == OP_INIT || cmd.op == OP_NODATA)
                round_reg <= '0;
            else if (cmd.op == OP_REND)
                round_reg <= round_reg + 1'b1;

            strobe_reg <= cmd.op inside {OP_EMIT_AF, OP_EMIT_G, OP_NODATA};
        end
    end

    // EM arithmetic registers
    always_ff @(posedge clk)
    begin
        t1_reg  <= cmd.idx;
        t2_reg  <= t1_reg;
        tbl_reg <= PHRED_TABLE[tbl_idx];

        // weight stage and running sum
        if (v2_reg)
        begin
            w_reg[t2_reg] <= wprod[W_W-1:0];
            prod_reg      <= wprod[W_W-1:0];
        end
        if (cmd.op == OP_RDW && cmd.idx == '0)
        begin
            sum_reg <= '0;
            sh_reg  <= '0;
        end
        else if (v3_reg)
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        else if (cmd.op == OP_NORM && !stat.norm_done && !stat.sum_zero)
        begin
            sum_reg <= sum_reg >> 1;
            sh_reg  <= sh_reg + 1'b1;
        end

        case (cmd.op)
            OP_INIT:
            begin
                for (int x = 0; x < MAX_ALLELES; x++)
                    af_reg[x] <= uniform_af(a_ld);
            end
            OP_PRIOR:
            begin
                prior_reg[cmd.idx] <= pf_val;
                if (cmd.idx == '0)
                begin
                    for (int x = 0; x < MAX_ALLELES; x++)
                        acc_reg[x] <= '0;
                    mse_reg <= '0;
                end
            end
            OP_ACC:
            begin
                for (int x = 0; x < MAX_ALLELES; x++)
                    acc_reg[x] <= acc_reg[x]
                        + ((gp.hi == ALLELE_W'(x)) ? ACC_W'(div_q) : '0)
                        + ((gp.lo == ALLELE_W'(x)) ? ACC_W'(div_q) : '0);
            end
            OP_UPD:
            begin
                d_reg      <= (nf > af_sel) ? (nf - af_sel) : (af_sel - nf);
                af_reg[ia] <= nf;
            end
            OP_SQ:   sq_reg  <= d_reg * d_reg;
            OP_MSE:  mse_reg <= mse_reg + MSE_W'(sq_reg);
            default: ;
        endcase

        // result payload
        samples_reg <= cnt_reg;
        case (cmd.op)
            OP_EMIT_AF:
            begin
                kind_reg   <= KIND_ALLELE;
                index_reg  <= cmd.idx;
                freq_reg   <= af_sel;
                rounds_reg <= round_reg;
                last_reg   <= 1'b0;
            end
            OP_EMIT_G:
            begin
                kind_reg   <= KIND_GENO;
                index_reg  <= cmd.idx;
                freq_reg   <= pf_val;
                rounds_reg <= round_reg;
                last_reg   <= (cmd.idx == g_ld - 1'b1);
            end
            OP_NODATA:
            begin
                kind_reg   <= KIND_NODATA;
                index_reg  <= '0;
                freq_reg   <= '0;
                rounds_reg <= '0;
                last_reg   <= 1'b1;
            end
            default: ;
        endcase
    end

    // Status to controller
    always_comb
    begin
        stat.nalleles    = a_ld;
        stat.ngenos      = g_ld;
        stat.nsamples    = cnt_reg;
        stat.nodata      = (ploidy_reg != 4'd2) || (acnt_reg < 3'd2) ||
                           (acnt_reg > 3'(MAX_ALLELES)) || (cnt_reg == '0);
        stat.pipe_busy   = v1_reg || v2_reg || v3_reg;
        stat.sum_zero    = (sum_reg == '0);
        stat.norm_done   = (sum_reg[SUM_W-1:NORM_BIT] == '0);
        stat.div_done    = div_done;
        stat.more_rounds = (round_reg < ROUND_W'(MAX_ROUNDS)) &&
                           (mse_reg > MSE_W'({tol_reg, 16'd0}));
    end

    assign strobe       = strobe_reg;
    assign kind         = kind_reg;
    assign index        = index_reg;
    assign freq         = freq_reg;
    assign samples_used = samples_reg;
    assign rounds       = rounds_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/hwe_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: loading, EM round sequencing and result emission.
// Depends on hwe_pkg; drives the datapath through dp_cmd_t.
module hwe_ctrl import hwe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      last_entry,
    output logic      busy,
    output dp_cmd_t   cmd,
    input  dp_stat_t  stat
);
    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_NODATA, S_INIT, S_PRIOR, S_WREAD, S_WDRAIN,
        S_NORM, S_DIVW, S_DIVWAIT, S_ACC, S_UDIV, S_UWAIT, S_UPD, S_SQ,
        S_MSE, S_REND, S_CHECK, S_EMIT_AF, S_EMIT_G
    } state_t;

    state_t             state_reg, state_next;
    logic [GENO_W-1:0]  idx_reg, idx_next;
    logic [SMP_W-1:0]   smp_reg, smp_next;
    dp_op_t             op;
    logic               last_geno;
    logic               last_allele;
    logic               last_smp;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        smp_next    = smp_reg;
        op          = OP_NONE;
        last_geno   = (idx_reg == stat.ngenos - 1'b1);
        last_allele = (idx_reg == {1'b0, stat.nalleles} - 1'b1);
        last_smp    = ({1'b0, smp_reg} == stat.nsamples - 1'b1);

        case (state_reg)
            S_IDLE:
            begin
                if (start && last_entry)
                    state_next = S_DECIDE;
            end
            S_DECIDE:   state_next = stat.nodata ? S_NODATA : S_INIT;
            S_NODATA:
            begin
                op         = OP_NODATA;
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                op         = OP_INIT;
                idx_next   = '0;
                state_next = S_PRIOR;
            end
            // priors for this round
            S_PRIOR:
            begin
                op = OP_PRIOR;
                if (last_geno)
                begin
                    idx_next   = '0;
                    smp_next   = '0;
                    state_next = S_WREAD;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            // weights of one sample
            S_WREAD:
            begin
                op = OP_RDW;
                if (last_geno)
                begin
                    idx_next   = '0;
                    state_next = S_WDRAIN;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_WDRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_NORM;
            end
            S_NORM:
            begin
                op = OP_NORM;
                if (stat.sum_zero)
                begin
                    idx_next = '0;
                    if (last_smp)
                        state_next = S_UDIV;
                    else
                    begin
                        smp_next   = smp_reg + 1'b1;
                        state_next = S_WREAD;
                    end
                end
                else if (stat.norm_done)
                    state_next = S_DIVW;
            end
            // posteriors
            S_DIVW:
            begin
                op         = OP_DIVW;
                state_next = S_DIVWAIT;
            end
            S_DIVWAIT:
            begin
                if (stat.div_done)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                op = OP_ACC;
                if (last_geno)
                begin
                    idx_next = '0;
                    if (last_smp)
                        state_next = S_UDIV;
                    else
                    begin
                        smp_next   = smp_reg + 1'b1;
                        state_next = S_WREAD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DIVW;
                end
            end
            // new allele frequencies and change
            S_UDIV:
            begin
                op         = OP_DIVU;
                state_next = S_UWAIT;
            end
            S_UWAIT:
            begin
                if (stat.div_done)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                op         = OP_UPD;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                op         = OP_SQ;
                state_next = S_MSE;
            end
            S_MSE:
            begin
                op = OP_MSE;
                if (last_allele)
                    state_next = S_REND;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_UDIV;
                end
            end
            S_REND:
            begin
                op         = OP_REND;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                idx_next   = '0;
                state_next = stat.more_rounds ? S_PRIOR : S_EMIT_AF;
            end
            // results
            S_EMIT_AF:
            begin
                op = OP_EMIT_AF;
                if (last_allele)
                begin
                    idx_next   = '0;
                    state_next = S_EMIT_G;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_EMIT_G:
            begin
                op = OP_EMIT_G;
                if (last_geno)
                    state_next = S_IDLE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            smp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            smp_reg   <= smp_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd.op   = op;
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.idx  = idx_reg;
    assign cmd.smp  = smp_reg;

endmodule

// ===== rtl/hwe_allele_frequency_em.sv =====
`timescale 1ns / 1ps
// Top level of the Hardy-Weinberg EM allele frequency block.
// Depends on hwe_pkg, hwe_ctrl, hwe_dp (which holds hwe_div).
//
//  channel  | handshake         | payload
//  ---------+-------------------+----------------------------------------------
//  input    | start & !busy     | pl_value, pl_missing, last_entry
//  result   | strobe (1 cycle)  | kind, index, freq, samples_used, rounds, last
//  config   | wr_en             | wr_index, wr_data
//
// Loading takes one beat per cycle. After the beat with last_entry, busy stays
// high while EM runs: each sample takes up to 13 normalize steps, and the
// divisions are paced by the shared 25-step divider; at most 50 rounds.
// Results then go out on a + g consecutive beats (g genotypes, a alleles; a
// single beat for no data). The receiver cannot stall.
// Reset is asynchronous; the store is not cleared and needs no clearing pass.
module hwe_allele_frequency_em import hwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PL_W-1:0]       pl_value,
    input  logic                  pl_missing,
    input  logic                  last_entry,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [TOL_W-1:0]      wr_data,
    output logic                  strobe,
    output logic [1:0]            kind,
    output logic [3:0]            index,
    output logic [FREQ_W-1:0]     freq,
    output logic [CNT_W-1:0]      samples_used,
    output logic [ROUND_W-1:0]    rounds,
    output logic                  last
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    hwe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .last_entry (last_entry),
        .busy       (busy),
        .cmd        (cmd),
        .stat       (stat)
    );

    hwe_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .pl_value     (pl_value),
        .pl_missing   (pl_missing),
        .strobe       (strobe),
        .kind         (kind),
        .index        (index),
        .freq         (freq),
        .samples_used (samples_used),
        .rounds       (rounds),
        .last         (last)
    );

endmodule

// ===== rtl/hwe_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the EM frequency block, bound to the top level.
// Depends on hwe_pkg.
module hwe_chk import hwe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [PL_W-1:0]       pl_value,
    input logic                  pl_missing,
    input logic                  last_entry,
    input logic                  wr_en,
    input logic [CFG_IDX_W-1:0]  wr_index,
    input logic [TOL_W-1:0]      wr_data,
    input logic                  strobe,
    input logic [1:0]            kind,
    input logic [3:0]            index,
    input logic [FREQ_W-1:0]     freq,
    input logic [CNT_W-1:0]      samples_used,
    input logic [ROUND_W-1:0]    rounds,
    input logic                  last
);
    // final beat of a site is alone
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("beat after last result");

    // a run stays busy until its last beat
    a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("idle before last result");

    // closing beat starts the run
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_entry |=> busy)
        else $error("last entry did not start estimation");

    // no-data beat shape
    a_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind == KIND_NODATA |-> last && freq == '0 && rounds == '0)
        else $error("malformed no-data result");

    // estimates come from at least one round over some samples
    a_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind != KIND_NODATA |-> rounds != '0 && samples_used != '0)
        else $error("estimate without rounds or samples");

endmodule

bind hwe_allele_frequency_em hwe_chk u_chk (.*);

// ===== tb/hwe_em_checker.sv =====
`timescale 1ns / 1ps
// Checker for the Hardy-Weinberg EM allele frequency block: watches the input,
// config and result ports, predicts each result beat and compares. Uses hwe_pkg.
module hwe_em_checker import hwe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [PL_W-1:0]       pl_value,
    input  logic                  pl_missing,
    input  logic                  last_entry,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [TOL_W-1:0]      wr_data,
    input  logic                  strobe,
    input  logic [1:0]            kind,
    input  logic [3:0]            index,
    input  logic [FREQ_W-1:0]     freq,
    input  logic [CNT_W-1:0]      samples_used,
    input  logic [ROUND_W-1:0]    rounds,
    input  logic                  last,
    output int                    fails,
    output int                    pending
);

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         index;
        logic [FREQ_W-1:0]  freq;
        logic [CNT_W-1:0]   samples;
        logic [ROUND_W-1:0] rounds;
        logic               last;
    } freq_beat_t;

    freq_beat_t        freq_expected[$];

    // predictor state
    logic [15:0]       pl_mem[STORE_DEPTH];
    logic [23:0]       prob_rom[PL_TABLE_DEPTH];
    longint unsigned   af_q[MAX_ALLELES];
    longint unsigned   prior_q[MAX_GENO];
    longint unsigned   acc_q[MAX_ALLELES];
    int unsigned       n_kept;
    int unsigned       entry_pos;
    int unsigned       em_rounds;
    bit                keep_cur;
    logic [3:0]        cfg_ploidy;
    logic [2:0]        cfg_alleles;
    logic [31:0]       cfg_tol;

    assign pending = freq_expected.size();

    // PHRED probability ROM: 10^(-k/10) in Q0.24
    initial
    begin
        longint unsigned tenth[10];
        longint unsigned pw;
        longint unsigned v;
        tenth = '{16777216, 13326616, 10585708, 8408526, 6679130,
                  5305422, 4214246, 3347495, 2659010, 2112126};
        for (int k = 0; k < PL_TABLE_DEPTH; k++)
        begin
            v = 0;
            if (k / 10 < 8)
            begin
                pw = 1;
                for (int t = 0; t < k / 10; t++) pw = pw * 10;
                v = (tenth[k % 10] + pw / 2) / pw;
            end
            if (v > 64'hFFFFFF) v = 64'hFFFFFF;
            prob_rom[k] = v[23:0];
        end
    end

    function automatic longint unsigned hw_pair(int i, int j);
        longint unsigned v;
        v = af_q[i] * af_q[j];
        if (i != j) v = v << 1;
        v = (v + (1 << 23)) >> 24;
        return (v > 64'd16777216) ? 64'd16777216 : v;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    task automatic push_beat(logic [1:0] k, int idx, longint unsigned f, bit lst);
        freq_beat_t b;
        b.kind    = k;
        b.index   = idx[3:0];
        b.freq    = f[FREQ_W-1:0];
        b.samples = n_kept[CNT_W-1:0];
        b.rounds  = em_rounds[ROUND_W-1:0];
        b.last    = lst;
        freq_expected.push_back(b);
    endtask

    // Full EM estimate from uniform frequencies
    task automatic estimate(int a, int g);
        longint unsigned w[MAX_GENO];
        longint unsigned sum;
        longint unsigned mse;
        longint unsigned nf;
        longint unsigned d;
        longint unsigned p;
        longint unsigned thresh;
        int sh;
        int gi;
        thresh = longint'(cfg_tol) << 16;
        for (int i = 0; i < a; i++) af_q[i] = (64'd16777216 + a / 2) / a;
        em_rounds = 0;
        do
        begin
            for (int i = 0; i < a; i++)
            begin
                acc_q[i] = 0;
                for (int j = 0; j <= i; j++) prior_q[i * (i + 1) / 2 + j] = hw_pair(i, j);
            end
            for (int s = 0; s < n_kept; s++)
            begin
                sum = 0;
                sh = 0;
                for (int k = 0; k < g; k++)
                begin
                    int plv;
                    plv = pl_mem[s * g + k];
                    if (plv >= PL_TABLE_DEPTH) plv = PL_TABLE_DEPTH - 1;
                    w[k] = prior_q[k] * prob_rom[plv];
                    sum += w[k];
                end
                if (sum == 0) continue;
                while ((sum >> sh) >= (64'd1 << 39)) sh++;
                sum = sum >> sh;
                for (int i = 0; i < a; i++)
                    for (int j = 0; j <= i; j++)
                    begin
                        gi = i * (i + 1) / 2 + j;
                        p = (((w[gi] >> sh) << 24) + sum / 2) / sum;
                        acc_q[i] += p;
                        acc_q[j] += p;
                    end
            end
            mse = 0;
            for (int i = 0; i < a; i++)
            begin
                nf = (acc_q[i] + n_kept) / (2 * longint'(n_kept));
                if (nf > 64'd16777216) nf = 64'd16777216;
                d = (nf > af_q[i]) ? nf - af_q[i] : af_q[i] - nf;
                mse += d * d;
                af_q[i] = nf;
            end
            em_rounds++;
        end
        while (em_rounds < MAX_ROUNDS && mse > thresh);
    endtask

    // One accepted likelihood beat
    task automatic absorb_pl(logic [15:0] plv, bit miss, bit lst);
        int a;
        int g;
        int pos;
        a = (cfg_alleles < 2) ? 2 : (cfg_alleles > MAX_ALLELES) ? MAX_ALLELES : cfg_alleles;
        g = a * (a + 1) / 2;
        pos = (entry_pos >= g) ? 0 : entry_pos;
        if (pos == 0) keep_cur = !miss && n_kept < MAX_SAMPLES;
        if (keep_cur) pl_mem[n_kept * g + pos] = miss ? 16'hFFFF : plv;
        if (pos == g - 1)
        begin
            if (keep_cur) n_kept++;
            keep_cur = 0;
            entry_pos = 0;
        end
        else
            entry_pos = pos + 1;
        if (!lst) return;
        if (cfg_ploidy != 2 || cfg_alleles < 2 || cfg_alleles > MAX_ALLELES || n_kept == 0)
        begin
            em_rounds = 0;
            push_beat(KIND_NODATA, 0, 0, 1);
        end
        else
        begin
            estimate(a, g);
            for (int i = 0; i < a; i++) push_beat(KIND_ALLELE, i, af_q[i], 0);
            for (int i = 0; i < a; i++)
                for (int j = 0; j <= i; j++) prior_q[i * (i + 1) / 2 + j] = hw_pair(i, j);
            for (int i = 0; i < g; i++) push_beat(KIND_GENO, i, prior_q[i], i == g - 1);
        end
        n_kept = 0;
        entry_pos = 0;
        keep_cur = 0;
    endtask

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        freq_beat_t e;
        if (!rst_n)
        begin
            fails       = 0;
            n_kept      = 0;
            entry_pos   = 0;
            em_rounds   = 0;
            keep_cur    = 0;
            cfg_ploidy  = 4'd2;
            cfg_alleles = 3'd2;
            cfg_tol     = 32'd4295;
        end
        else
        begin
            if (strobe)
            begin
                if (freq_expected.size() == 0)
                    report_mismatch("unexpected result beat, index", index, 0);
                else
                begin
                    e = freq_expected.pop_front();
                    if (kind != e.kind)            report_mismatch("kind", kind, e.kind);
                    if (index != e.index)          report_mismatch("index", index, e.index);
                    if (freq != e.freq)            report_mismatch("freq", freq, e.freq);
                    if (samples_used != e.samples) report_mismatch("samples_used",
                                                                   samples_used, e.samples);
                    if (rounds != e.rounds)        report_mismatch("rounds", rounds, e.rounds);
                    if (last != e.last)            report_mismatch("last", last, e.last);
                end
            end
            if (wr_en)
            begin
                if (wr_index == REG_PLOIDY)       cfg_ploidy  = wr_data[3:0];
                else if (wr_index == REG_ALLELES) cfg_alleles = wr_data[2:0];
                else if (wr_index == REG_TOL)     cfg_tol     = wr_data;
            end
            if (start && !busy)
                absorb_pl(pl_value, pl_missing, last_entry);
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for hwe_allele_frequency_em: clock, reset, site stimulus with
// bursty pacing, config phases and verdict. Uses hwe_pkg and hwe_em_checker.
module tb;
    import hwe_pkg::*;

    localparam int STALL_LIMIT = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PL_W-1:0]       pl_value;
    logic                  pl_missing;
    logic                  last_entry;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [TOL_W-1:0]      wr_data;
    logic                  strobe;
    logic [1:0]            kind;
    logic [3:0]            index;
    logic [FREQ_W-1:0]     freq;
    logic [CNT_W-1:0]      samples_used;
    logic [ROUND_W-1:0]    rounds;
    logic                  last;
    int                    fails;
    int                    pending;
    int                    burst_left;
    int                    quiet_cycles;
    int                    cur_alleles;

    hwe_allele_frequency_em DUT (.*);

    hwe_em_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One input beat, with bursty pacing
    task automatic send_pl(logic [15:0] plv, bit miss, bit lst);
        if (burst_left <= 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
        end
        start      <= 1;
        pl_value   <= plv;
        pl_missing <= miss;
        last_entry <= lst;
        @(posedge clk);
        while (busy) @(posedge clk);
        burst_left--;
    endtask

    // Hold off until all results are in and the block is quiet
    task automatic drain();
        start <= 0;
        repeat (2) @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        drain();
        wr_en    <= 1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 0;
        if (idx == REG_ALLELES) cur_alleles = int'(data[2:0]);
    endtask

    function automatic logic [15:0] rand_pl();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 16'($urandom_range(0, 60));
        if (r < 80) return 16'($urandom_range(0, 255));
        if (r < 95) return 16'($urandom);
        return 16'd0;
    endfunction

    // One site of nsamp samples; noisy adds missing entries and early ends
    task automatic send_site(int nsamp, bit noisy);
        int a;
        int g;
        int cut;
        bit miss;
        a = (cur_alleles < 2) ? 2 : (cur_alleles > MAX_ALLELES) ? MAX_ALLELES : cur_alleles;
        g = a * (a + 1) / 2;
        cut = (noisy && $urandom_range(0, 3) == 0) ? $urandom_range(0, nsamp * g - 1) : -1;
        if (nsamp == 0)
        begin
            send_pl(rand_pl(), 1, 1);
            return;
        end
        for (int s = 0; s < nsamp; s++)
            for (int k = 0; k < g; k++)
            begin
                miss = noisy && ($urandom_range(0, 19) == 0);
                if (s * g + k == cut || (s == nsamp - 1 && k == g - 1))
                begin
                    send_pl(rand_pl(), miss, 1);
                    return;
                end
                send_pl(rand_pl(), miss, 0);
            end
    endtask

    initial
    begin
        int nbeats;
        start       = 0;
        pl_value    = 0;
        pl_missing  = 0;
        last_entry  = 0;
        wr_en       = 0;
        wr_index    = REG_PLOIDY;
        wr_data     = 0;
        burst_left  = 0;
        cur_alleles = 2;
        rst_n       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: one clean sample, all zero PL
        send_pl(0, 0, 0); send_pl(0, 0, 0); send_pl(0, 0, 1);
        // PL above the table and full-scale value; missing non-first entry
        send_pl(16'hFFFF, 0, 0); send_pl(300, 1, 0); send_pl(0, 0, 0);
        // zero likelihood sum sample followed by a normal one
        send_pl(90, 0, 0); send_pl(200, 0, 0); send_pl(80, 0, 0);
        send_pl(10, 0, 0); send_pl(0, 0, 0); send_pl(30, 0, 1);
        // missing first entry drops the sample; no samples gives no data
        send_pl(5, 1, 0); send_pl(6, 0, 0); send_pl(7, 0, 1);
        // partial sample at the end is dropped
        send_pl(3, 0, 0); send_pl(4, 0, 0); send_pl(5, 0, 0); send_pl(9, 0, 1);
        // ploidy other than 2
        write_reg(REG_PLOIDY, 3);
        send_pl(1, 0, 0); send_pl(2, 0, 0); send_pl(3, 0, 1);
        write_reg(REG_PLOIDY, 2);
        // allele count out of range, then four alleles with zero tolerance
        write_reg(REG_ALLELES, 7);
        send_site(1, 0);
        write_reg(REG_ALLELES, 4);
        write_reg(REG_TOL, 0);
        send_site(1, 0);

        // random sites
        nbeats = 0;
        while (nbeats < 210)
        begin
            int a;
            int ns;
            int r;
            r = $urandom_range(0, 19);
            if (r == 0)
                write_reg(REG_PLOIDY, $urandom_range(0, 1) ? 2 : $urandom_range(0, 15));
            else if (r < 4)
            begin
                a = $urandom_range(0, 9);
                write_reg(REG_ALLELES, (a < 6) ? 2 : (a < 8) ? a - 3 : $urandom_range(0, 7));
            end
            else if (r < 6)
            begin
                a = $urandom_range(0, 3);
                write_reg(REG_TOL, (a == 0) ? 0 : (a == 1) ? 32'hFFFF_FFFF :
                                   (a == 2) ? $urandom_range(0, 20000) : $urandom);
            end
            ns = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            send_site(ns, $urandom_range(0, 3) == 0);
            a = (cur_alleles < 2) ? 2 : (cur_alleles > 4) ? 4 : cur_alleles;
            nbeats += (ns == 0) ? 1 : ns * a * (a + 1) / 2;
        end

        drain();
        repeat (50) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
